/* rtl/nbfs_pkg.sv */
package nbfs_pkg;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int BIT_W    = 3;
   localparam int NOZZLE_W = 4;
   localparam int PULSE_W  = 4;

   // op codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIRE  = 2'd2;

   localparam logic [BIT_W-1:0]   BIT_LAST    = 3'd7;
   localparam logic [PULSE_W-1:0] PULSE_RESET = 4'd15;

   // per-item info handed from the sequencer to the result stage
   typedef struct packed {
      logic                is_fire;
      logic                zero_byte;   // reading entry 0 while unwritten since reset/clear
      logic [BIT_W-1:0]    bit_pos;
      logic [NOZZLE_W-1:0] nozzle;
   } fire_info_type;

endpackage

/* rtl/nbfs_ram.sv */
module nbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nbfs_seq.sv */
module nbfs_seq #(
   parameter int BUFFER_DEPTH = 512,
   parameter int NOZZLE_COUNT = 12,
   localparam int PTR_W = $clog2(BUFFER_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [nbfs_pkg::OP_W-1:0]     op,
   input  logic [nbfs_pkg::BYTE_W-1:0]   data_byte,
   output logic                          wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic [nbfs_pkg::BYTE_W-1:0]   wr_data,
   output logic                          rd_en,
   output logic [PTR_W-1:0]              rd_addr,
   output nbfs_pkg::fire_info_type       info
);

   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(BUFFER_DEPTH - 1);
   localparam logic [nbfs_pkg::NOZZLE_W-1:0] NOZ_LAST =
      nbfs_pkg::NOZZLE_W'(NOZZLE_COUNT - 1);

   logic [PTR_W-1:0]                wp_ff, wp_in;
   logic [PTR_W-1:0]                rp_ff, rp_in;
   logic [nbfs_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [nbfs_pkg::NOZZLE_W-1:0]   noz_ff, noz_in;
   logic                            ent0_ff, ent0_in;
   logic [PTR_W:0]                  rp_step;

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      bit_in  = bit_ff;
      noz_in  = noz_ff;
      ent0_in = ent0_ff;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      rp_step = {1'b0, rp_ff};
      if (accept) begin
         unique case (op)
            nbfs_pkg::OP_CLEAR: begin
               wp_in   = '0;
               rp_in   = '0;
               bit_in  = '0;
               noz_in  = '0;
               ent0_in = 1'b0;
            end
            nbfs_pkg::OP_WRITE: begin
               wr_en = 1'b1;
               wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
               if (wp_ff == '0) begin
                  ent0_in = 1'b1;
               end
            end
            nbfs_pkg::OP_FIRE: begin
               rd_en  = 1'b1;
               noz_in = (noz_ff >= NOZ_LAST) ? '0 : noz_ff + 1'b1;
               if (bit_ff == nbfs_pkg::BIT_LAST) begin
                  bit_in  = '0;
                  rp_step = {1'b0, rp_ff} + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
               // caught up with the writer: restart at byte 0, bit 0
               if (rp_step >= {1'b0, wp_ff}) begin
                  rp_in  = '0;
                  bit_in = '0;
               end else begin
                  rp_in = rp_step[PTR_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         bit_ff  <= '0;
         noz_ff  <= '0;
         ent0_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         bit_ff  <= bit_in;
         noz_ff  <= noz_in;
         ent0_ff <= ent0_in;
      end
   end

   assign wr_addr        = wp_ff;
   assign wr_data        = data_byte;
   assign rd_addr        = rp_ff;
   assign info.is_fire   = (op == nbfs_pkg::OP_FIRE);
   assign info.zero_byte = (rp_ff == '0) && !ent0_ff;
   assign info.bit_pos   = bit_ff;
   assign info.nozzle    = noz_ff;

   nozzle_in_range: assert property (@(posedge clock) disable iff (reset)
      noz_ff <= NOZ_LAST)
      else $error("nozzle counter out of range");

   read_ptr_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= LAST_ADDR && wp_ff <= LAST_ADDR)
      else $error("buffer pointer beyond depth");

   clear_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && op == nbfs_pkg::OP_CLEAR |=> wp_ff == '0 && rp_ff == '0 && !ent0_ff)
      else $error("clear did not restart pointers");

endmodule

/* rtl/nozzle_bitmap_fire_sequencer_core.sv */
// Printhead nozzle sequencer. Bitmap bytes (req_tuser = write) go into a ring
// buffer of BUFFER_DEPTH bytes; each fire tick (req_tuser = fire) reads the
// next bit, LSB first, and returns fire, the nozzle number (cycling through
// 0..NOZZLE_COUNT-1) and the pulse width (csr pulse length when fire is set,
// else 0). When reading catches up with writing it restarts at byte 0, bit 0.
// A clear item restarts both pointers, the bit position and the nozzle count
// and makes buffer entry 0 read as zero. Clear, write and the unused op code
// return an all-zero result. Every item gives exactly one result. One item
// is taken per cycle while the response stream does not stall; a result
// passes through the registered read of the buffer RAM and then the result
// register. csr_ready is always high; the pulse length resets to 15.
module nozzle_bitmap_fire_sequencer_core #(
   parameter int BUFFER_DEPTH = 512,
   parameter int NOZZLE_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] fire, [4:1] nozzle, [8:5] pulse_width, rest 0
   // pulse length register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // [3:0] pulse_length
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);

   logic                          accept;
   logic                          wr_en, rd_en;
   logic [PTR_W-1:0]              wr_addr, rd_addr;
   logic [nbfs_pkg::BYTE_W-1:0]   wr_data, rd_data;
   nbfs_pkg::fire_info_type       info;

   // stage 1: RAM read data plus info captured with it
   logic                          s1_valid_ff, s1_valid_in;
   nbfs_pkg::fire_info_type       s1_info_ff;
   // stage 2: result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_fire_ff, rsp_fire_in;
   logic [nbfs_pkg::NOZZLE_W-1:0] rsp_nozzle_ff, rsp_nozzle_in;
   logic [nbfs_pkg::PULSE_W-1:0]  rsp_pulse_ff, rsp_pulse_in;
   logic [nbfs_pkg::PULSE_W-1:0]  pulse_len_ff;

   logic                          rsp_load, s1_load;
   logic [nbfs_pkg::BYTE_W-1:0]   cur_byte;

   // the pipeline moves whenever the slot ahead is free or being emptied
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || rsp_load;
   assign req_tready = s1_load;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   nbfs_seq #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .NOZZLE_COUNT (NOZZLE_COUNT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_tuser),
      .data_byte (req_tdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   // read data only updates on a fire transfer, so it holds while stage 1 stalls
   nbfs_ram #(
      .WIDTH (nbfs_pkg::BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry 0 reads as zero until written after reset or clear
   assign cur_byte = s1_info_ff.zero_byte ? '0 : rd_data;

   always_comb begin
      s1_valid_in   = s1_load ? accept : s1_valid_ff;
      rsp_valid_in  = rsp_load ? s1_valid_ff : rsp_valid_ff;
      rsp_fire_in   = s1_info_ff.is_fire && cur_byte[s1_info_ff.bit_pos];
      rsp_nozzle_in = s1_info_ff.is_fire ? s1_info_ff.nozzle : '0;
      rsp_pulse_in  = rsp_fire_in ? pulse_len_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pulse_len_ff <= nbfs_pkg::PULSE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            pulse_len_ff <= csr_data;
         end
      end
      if (s1_load) begin
         s1_info_ff <= info;
      end
      if (rsp_load) begin
         rsp_fire_ff   <= rsp_fire_in;
         rsp_nozzle_ff <= rsp_nozzle_in;
         rsp_pulse_ff  <= rsp_pulse_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_pulse_ff, rsp_nozzle_ff, rsp_fire_ff};

   no_pulse_without_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_fire_ff |-> rsp_pulse_ff == '0)
      else $error("pulse width set on a non-fire result");

   nozzle_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_nozzle_ff <= nbfs_pkg::NOZZLE_W'(NOZZLE_COUNT - 1))
      else $error("nozzle number out of range");

   transfer_enters_stage1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost before stage 1");

   csr_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> pulse_len_ff == $past(csr_data))
      else $error("pulse length write lost");

endmodule
